// ===== hdl/ffpa_pkg.sv =====
package ffpa_pkg;

    localparam int NUM_PAGES    = 1024;
    localparam int PAGE_BYTES   = 4096;
    localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
    localparam int PAGE_W       = $clog2(NUM_PAGES);
    localparam int CNT_W        = $clog2(NUM_PAGES + 1);
    localparam int ADDR_W       = 32;
    localparam int BYTES_W      = 23;
    localparam int SIZE_PAGES_W = 11;
    localparam int TOTAL_W      = 11;
    localparam int OPCODE_W     = 2;
    localparam int REQ_W        = (BYTES_W - PAGE_SHIFT + 1 > SIZE_PAGES_W) ?
                                  (BYTES_W - PAGE_SHIFT + 1) : SIZE_PAGES_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC_BYTES,
        OP_ALLOC_PAGES,
        OP_FREE
    } t_opcode;

    typedef struct packed {
        logic              used;
        logic [PAGE_W-1:0] owner;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] waddr;
        t_entry            wdata;
        logic [PAGE_W-1:0] raddr;
    } t_mem_req;

endpackage

// ===== hdl/ffpa_req_if.sv =====
interface ffpa_req_if import ffpa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OPCODE_W-1:0]     opcode;
    logic [BYTES_W-1:0]      size_bytes;
    logic [SIZE_PAGES_W-1:0] size_pages;
    logic [ADDR_W-1:0]       free_address;
    logic                    kernel_ok;

    modport source (
        output valid, opcode, size_bytes, size_pages, free_address, kernel_ok,
        input  ready
    );
    modport sink (
        input  valid, opcode, size_bytes, size_pages, free_address, kernel_ok,
        output ready
    );
endinterface

// ===== hdl/ffpa_rsp_if.sv =====
interface ffpa_rsp_if import ffpa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               success;
    logic [ADDR_W-1:0]  result_address;
    logic [TOTAL_W-1:0] page_total;

    modport source (
        output valid, success, result_address, page_total,
        input  ready
    );
    modport sink (
        input  valid, success, result_address, page_total,
        output ready
    );
endinterface

// ===== hdl/ffpa_page_map.sv =====
module ffpa_page_map import ffpa_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_mem,
    output t_entry   o_rd
);

    t_entry r_mem [NUM_PAGES];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.waddr] <= i_mem.wdata;
        end
        r_rd <= r_mem[i_mem.raddr];
    end

    assign o_rd = r_rd;

endmodule

// ===== hdl/ffpa_ctrl.sv =====
module ffpa_ctrl import ffpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ADDR_W-1:0] i_heap_base,
    ffpa_req_if.sink          i_req,
    ffpa_rsp_if.source        o_rsp,
    output t_mem_req          o_mem,
    input  t_entry            i_rd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_WALK,
        S_RESP
    } t_state;

    t_state             r_state;
    logic [PAGE_W-1:0]  r_addr;
    logic [CNT_W-1:0]   r_run;
    logic [CNT_W-1:0]   r_pages;
    logic [CNT_W-1:0]   r_cnt;
    logic [PAGE_W-1:0]  r_first;
    logic [PAGE_W-1:0]  r_owner;
    logic               r_head;
    logic               r_commit;
    logic               r_res_ok;
    logic [ADDR_W-1:0]  r_res_addr;
    logic [TOTAL_W-1:0] r_res_total;
    logic               r_out_valid;
    logic               r_out_ok;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [TOTAL_W-1:0] r_out_total;

    t_opcode            w_op;
    logic               w_acc;
    logic [BYTES_W:0]   w_bytes_sum;
    logic [REQ_W-1:0]   w_req_pages;
    logic               w_alloc_bad;
    logic [ADDR_W:0]    w_off;
    logic [ADDR_W-1:0]  w_page_full;
    logic               w_free_bad;
    logic [PAGE_W-1:0]  w_free_page;
    logic [CNT_W-1:0]   n_run;
    logic [PAGE_W-1:0]  w_first;
    logic               w_last;
    logic               w_match;
    logic [PAGE_W-1:0]  w_addr_inc;

    assign w_op  = t_opcode'(i_req.opcode);
    assign w_acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // request size in pages, bytes rounded up
    assign w_bytes_sum = {1'b0, i_req.size_bytes} + (BYTES_W + 1)'(PAGE_BYTES - 1);
    always_comb begin
        case (w_op)
            OP_ALLOC_BYTES: w_req_pages = REQ_W'(w_bytes_sum >> PAGE_SHIFT);
            default:        w_req_pages = REQ_W'(i_req.size_pages);
        endcase
    end
    assign w_alloc_bad = (w_req_pages == '0) || (32'(w_req_pages) > 32'(NUM_PAGES));

    // address to page for free
    assign w_off       = {1'b0, i_req.free_address} - {1'b0, i_heap_base};
    assign w_page_full = w_off[ADDR_W-1:0] >> PAGE_SHIFT;
    assign w_free_bad  = w_off[ADDR_W] || (w_page_full >= 32'(NUM_PAGES));
    assign w_free_page = w_page_full[PAGE_W-1:0];

    assign w_addr_inc = r_addr + PAGE_W'(1);
    assign w_last     = (r_addr == PAGE_W'(NUM_PAGES - 1));
    assign n_run      = i_rd.used ? '0 : r_run + CNT_W'(1);
    assign w_first    = PAGE_W'(CNT_W'(r_addr) + CNT_W'(1) - r_pages);
    assign w_match    = i_rd.used && (r_head || (i_rd.owner == r_owner));

    always_comb begin
        o_mem = '0;
        case (r_state)
            S_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_addr;
            end
            S_IDLE: begin
                o_mem.raddr = (w_op == OP_FREE) ? w_free_page : '0;
            end
            S_SCAN: begin
                o_mem.raddr = w_addr_inc;
            end
            S_FILL: begin
                o_mem.we          = 1'b1;
                o_mem.waddr       = r_addr;
                o_mem.wdata.used  = 1'b1;
                o_mem.wdata.owner = r_first;
            end
            S_WALK: begin
                o_mem.raddr = w_addr_inc;
                o_mem.we    = w_match;
                o_mem.waddr = r_addr;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_addr <= w_addr_inc;
                    if (w_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_res_ok    <= 1'b0;
                    r_res_addr  <= '0;
                    r_res_total <= '0;
                    if (w_acc) begin
                        case (w_op)
                            OP_ALLOC_BYTES, OP_ALLOC_PAGES: begin
                                if (w_alloc_bad) begin
                                    r_state <= S_RESP;
                                end else begin
                                    r_pages  <= CNT_W'(w_req_pages);
                                    r_commit <= i_req.kernel_ok;
                                    r_addr   <= '0;
                                    r_run    <= '0;
                                    r_state  <= S_SCAN;
                                end
                            end
                            OP_FREE: begin
                                if (w_free_bad) begin
                                    r_state <= S_RESP;
                                end else begin
                                    r_addr  <= w_free_page;
                                    r_head  <= 1'b1;
                                    r_cnt   <= '0;
                                    r_state <= S_WALK;
                                end
                            end
                            default: begin
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_run <= n_run;
                    if (n_run == r_pages) begin
                        if (r_commit) begin
                            r_first <= w_first;
                            r_addr  <= w_first;
                            r_cnt   <= r_pages;
                            r_state <= S_FILL;
                        end else begin
                            r_state <= S_RESP;
                        end
                    end else if (w_last) begin
                        r_state <= S_RESP;
                    end else begin
                        r_addr <= w_addr_inc;
                    end
                end
                S_FILL: begin
                    r_addr <= w_addr_inc;
                    r_cnt  <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_res_ok    <= 1'b1;
                        r_res_addr  <= i_heap_base + (ADDR_W'(r_first) << PAGE_SHIFT);
                        r_res_total <= TOTAL_W'(r_pages);
                        r_state     <= S_RESP;
                    end
                end
                S_WALK: begin
                    if (w_match) begin
                        r_cnt  <= r_cnt + CNT_W'(1);
                        r_head <= 1'b0;
                        if (r_head) begin
                            r_owner <= i_rd.owner;
                        end
                        if (w_last) begin
                            r_res_ok    <= 1'b1;
                            r_res_total <= TOTAL_W'(r_cnt + CNT_W'(1));
                            r_state     <= S_RESP;
                        end else begin
                            r_addr <= w_addr_inc;
                        end
                    end else begin
                        r_res_ok    <= (r_cnt != '0);
                        r_res_total <= TOTAL_W'(r_cnt);
                        r_state     <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_ok    <= r_res_ok;
                        r_out_addr  <= r_res_addr;
                        r_out_total <= r_res_total;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.success        = r_out_ok;
    assign o_rsp.result_address = r_out_addr;
    assign o_rsp.page_total     = r_out_total;

endmodule

// ===== hdl/first_fit_page_allocator_core.sv =====
// First-fit page allocator over a heap of NUM_PAGES pages held in one synchronous page-map
// memory. After reset the block clears every entry of the map and takes no request;
// heap_base may be written meanwhile. An allocation reads the map one entry a cycle from
// page 0 until a long enough free run is found or the last page is passed, then writes the
// run one entry a cycle when it commits. A free walks forward one entry a cycle while the
// owner matches. Invalid requests go straight to the response state. One request is in
// progress at a time; a finished response waits in the output register while the next
// request is accepted.
module first_fit_page_allocator_core import ffpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_wdata,
    ffpa_req_if.sink          i_req,
    ffpa_rsp_if.source        o_rsp
);

    logic [ADDR_W-1:0] r_heap_base;
    t_mem_req          w_mem;
    t_entry            w_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
        end else if (i_cfg_we) begin
            r_heap_base <= i_cfg_wdata;
        end
    end

    ffpa_page_map u_page_map (
        .i_clk (i_clk),
        .i_mem (w_mem),
        .o_rd  (w_rd)
    );

    ffpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_heap_base (r_heap_base),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_mem       (w_mem),
        .i_rd        (w_rd)
    );

endmodule

// ===== hdl/ffpa_checker.sv =====
module ffpa_checker import ffpa_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_valid,
    input logic               i_req_ready,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic               i_rsp_success,
    input logic [ADDR_W-1:0]  i_rsp_address,
    input logic [TOTAL_W-1:0] i_rsp_total
);

    // no response straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    // one request in flight
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while another is in progress");

    // failures report zero fields
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_success) |-> (i_rsp_address == '0 && i_rsp_total == '0))
        else $error("failed response with non-zero fields");

    // success always moves at least one page
    a_ok_pages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_success) |-> (i_rsp_total != '0))
        else $error("successful response with no pages");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_success) && $stable(i_rsp_address)
             && $stable(i_rsp_total)))
        else $error("stalled response changed");

endmodule

bind first_fit_page_allocator_core ffpa_checker u_ffpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_success (o_rsp.success),
    .i_rsp_address (o_rsp.result_address),
    .i_rsp_total   (o_rsp.page_total)
);
